### sv/afie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afie_pkg;

   // Table geometry and per-read segment limit.
   localparam int FRAME_DEPTH      = 1024;
   localparam int INDEX_WIDTH      = $clog2(FRAME_DEPTH);
   localparam int COUNT_WIDTH      = $clog2(FRAME_DEPTH + 1);
   localparam int MAX_SEGMENTS     = 16;
   localparam int SEG_COUNT_WIDTH  = $clog2(MAX_SEGMENTS + 1);

   // Field widths.
   localparam int MODE_WIDTH       = 2;
   localparam int STATUS_WIDTH     = 2;
   localparam int OFFSET_WIDTH     = 40;
   localparam int LENGTH_WIDTH     = 32;
   localparam int SAMPLE_WIDTH     = 40;
   localparam int FRAME_SMP_WIDTH  = 32;
   localparam int BYTE_TOTAL_WIDTH = 48;
   localparam int ALIGN_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH  = 1;
   localparam int BIT_COUNT_WIDTH  = $clog2(LENGTH_WIDTH);

   localparam logic [COUNT_WIDTH-1:0] FRAME_DEPTH_COUNT = COUNT_WIDTH'(FRAME_DEPTH);
   localparam logic [SEG_COUNT_WIDTH-1:0] MAX_SEG_COUNT = SEG_COUNT_WIDTH'(MAX_SEGMENTS);
   localparam logic [BIT_COUNT_WIDTH-1:0] ROOM_MSB = BIT_COUNT_WIDTH'(LENGTH_WIDTH - 1);
   localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {SAMPLE_WIDTH{1'b1}};
   localparam logic [ALIGN_WIDTH-1:0] ALIGN_ONE = ALIGN_WIDTH'(1);

   // Request modes.
   localparam logic [MODE_WIDTH-1:0] MODE_APPEND = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_SEEK   = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_READ   = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_NOP    = 2'd3;

   // Response status codes.
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_END     = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_TOO_BIG = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PCM_MODE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALIGN    = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_APPEND,
      ST_SEEK_ADDR,
      ST_SEEK_CMP,
      ST_SEEK_EMIT,
      ST_ALIGN,
      ST_PCM_ADDR,
      ST_PCM_SEG,
      ST_WF_EMIT,
      ST_CUR_EMIT
   } state_type;

endpackage

`default_nettype wire

### sv/audio_frame_index_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+---------------------------------
// request   | start, busy, req_*                      | word taken when start && !busy
// response  | rsp_valid, rsp_*                        | word valid for one cycle only
// config    | csr_write_enable, csr_index, csr_data   | written on any edge with enable
//
// An append passes through the append state. A seek visits the address and compare
// states once per binary search step, at most eleven steps at the full depth of 1024
// frames, then the seek emit state. A whole-frame read or a no-operation word goes to
// its emit state. A PCM read runs the shift-and-subtract remainder unit that trims the
// request to whole alignment units, then visits the address and segment states for each
// frame, as each frame needs one pass through the registered read port of the frame table,
// and closes from the address or current emit state. The block takes no new word while busy.
// Reset is synchronous and clears all control state; the frame table needs no clearing
// pass, as only entries below the entry count are ever used. The receiver cannot stall
// the response channel.

module audio_frame_index_engine (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output      logic                                   busy,
   input  wire logic [afie_pkg::MODE_WIDTH-1:0]        req_mode,
   input  wire logic [afie_pkg::OFFSET_WIDTH-1:0]      req_frame_offset,
   input  wire logic [afie_pkg::LENGTH_WIDTH-1:0]      req_frame_length,
   input  wire logic [afie_pkg::FRAME_SMP_WIDTH-1:0]   req_frame_samples,
   input  wire logic [afie_pkg::SAMPLE_WIDTH-1:0]      req_seek_sample,
   input  wire logic [afie_pkg::LENGTH_WIDTH-1:0]      req_read_size,
   output      logic                                   rsp_valid,
   output      logic [afie_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output      logic [afie_pkg::OFFSET_WIDTH-1:0]      rsp_segment_offset,
   output      logic [afie_pkg::LENGTH_WIDTH-1:0]      rsp_segment_length,
   output      logic [afie_pkg::SAMPLE_WIDTH-1:0]      rsp_found_sample,
   output      logic [afie_pkg::SAMPLE_WIDTH-1:0]      rsp_total_samples,
   output      logic [afie_pkg::LENGTH_WIDTH-1:0]      rsp_max_frame_length,
   output      logic                                   rsp_last,
   input  wire logic                                   csr_write_enable,
   input  wire logic [afie_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [afie_pkg::ALIGN_WIDTH-1:0]       csr_data
);

   // ------------------------------------------------------------------
   // Declarations
   // ------------------------------------------------------------------
   afie_pkg::state_type state_ff, state_in;

   // Configuration.
   logic                                   pcm_mode_ff;
   logic [afie_pkg::ALIGN_WIDTH-1:0]       align_ff;

   // Latched request word.
   logic [afie_pkg::MODE_WIDTH-1:0]        op_mode_ff, op_mode_in;
   logic [afie_pkg::OFFSET_WIDTH-1:0]      op_offset_ff, op_offset_in;
   logic [afie_pkg::LENGTH_WIDTH-1:0]      op_length_ff, op_length_in;
   logic [afie_pkg::FRAME_SMP_WIDTH-1:0]   op_samples_ff, op_samples_in;
   logic [afie_pkg::SAMPLE_WIDTH-1:0]      op_target_ff, op_target_in;

   // Index state.
   logic [afie_pkg::COUNT_WIDTH-1:0]       entry_count_ff, entry_count_in;
   logic [afie_pkg::COUNT_WIDTH-1:0]       cursor_frame_ff, cursor_frame_in;
   logic [afie_pkg::LENGTH_WIDTH-1:0]      cursor_byte_ff, cursor_byte_in;
   logic [afie_pkg::SAMPLE_WIDTH-1:0]      sample_total_ff, sample_total_in;
   logic [afie_pkg::BYTE_TOTAL_WIDTH-1:0]  byte_total_ff, byte_total_in;
   logic [afie_pkg::LENGTH_WIDTH-1:0]      largest_ff, largest_in;

   // Sequencer working registers.
   logic [afie_pkg::COUNT_WIDTH-1:0]       lo_ff, lo_in;
   logic [afie_pkg::COUNT_WIDTH-1:0]       hi_ff, hi_in;
   logic [afie_pkg::COUNT_WIDTH-1:0]       mid_ff, mid_in;
   logic [afie_pkg::LENGTH_WIDTH-1:0]      room_ff, room_in;
   logic [afie_pkg::ALIGN_WIDTH-1:0]       rem_ff, rem_in;
   logic [afie_pkg::BIT_COUNT_WIDTH-1:0]   bit_ctr_ff, bit_ctr_in;
   logic [afie_pkg::SEG_COUNT_WIDTH-1:0]   seg_count_ff, seg_count_in;

   // One segment held back until it is known whether it is the final one.
   logic                                   pend_valid_ff, pend_valid_in;
   logic [afie_pkg::OFFSET_WIDTH-1:0]      pend_offset_ff, pend_offset_in;
   logic [afie_pkg::LENGTH_WIDTH-1:0]      pend_length_ff, pend_length_in;
   logic [afie_pkg::SAMPLE_WIDTH-1:0]      pend_found_ff, pend_found_in;

   // Frame table and its registered read port.
   logic [afie_pkg::OFFSET_WIDTH-1:0]      entry_offset_ff [afie_pkg::FRAME_DEPTH];
   logic [afie_pkg::LENGTH_WIDTH-1:0]      entry_length_ff [afie_pkg::FRAME_DEPTH];
   logic [afie_pkg::SAMPLE_WIDTH-1:0]      entry_start_ff  [afie_pkg::FRAME_DEPTH];
   logic [afie_pkg::OFFSET_WIDTH-1:0]      rd_offset_ff;
   logic [afie_pkg::LENGTH_WIDTH-1:0]      rd_length_ff;
   logic [afie_pkg::SAMPLE_WIDTH-1:0]      rd_start_ff;
   logic [afie_pkg::INDEX_WIDTH-1:0]       rd_addr;
   logic                                   wr_en;

   // Response registers.
   logic                                   rsp_valid_ff;
   logic [afie_pkg::STATUS_WIDTH-1:0]      rsp_status_ff;
   logic [afie_pkg::OFFSET_WIDTH-1:0]      rsp_offset_ff;
   logic [afie_pkg::LENGTH_WIDTH-1:0]      rsp_length_ff;
   logic [afie_pkg::SAMPLE_WIDTH-1:0]      rsp_found_ff;
   logic [afie_pkg::SAMPLE_WIDTH-1:0]      rsp_total_ff;
   logic [afie_pkg::LENGTH_WIDTH-1:0]      rsp_max_ff;
   logic                                   rsp_last_ff;

   // Response word being formed this cycle.
   logic                                   emit;
   logic [afie_pkg::STATUS_WIDTH-1:0]      emit_status;
   logic [afie_pkg::OFFSET_WIDTH-1:0]      emit_offset;
   logic [afie_pkg::LENGTH_WIDTH-1:0]      emit_length;
   logic [afie_pkg::SAMPLE_WIDTH-1:0]      emit_found;
   logic                                   emit_last;

   // Datapath helpers.
   logic                                   accept;
   logic                                   cursor_in_table;
   logic [afie_pkg::SAMPLE_WIDTH:0]        sample_sum;
   logic [afie_pkg::ALIGN_WIDTH-1:0]       align_eff;
   logic [afie_pkg::ALIGN_WIDTH:0]         rem_trial;
   logic [afie_pkg::ALIGN_WIDTH:0]         rem_step;
   logic [afie_pkg::LENGTH_WIDTH-1:0]      frame_rem;
   logic [afie_pkg::OFFSET_WIDTH-1:0]      seg_offset;
   logic [afie_pkg::COUNT_WIDTH-1:0]       seek_mid;
   logic [afie_pkg::COUNT_WIDTH-1:0]       seek_pick;

   assign accept          = start && !busy;
   assign busy            = (state_ff != afie_pkg::ST_IDLE);
   assign cursor_in_table = (cursor_frame_ff < entry_count_ff);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pcm_mode_ff <= 1'b0;
         align_ff    <= afie_pkg::ALIGN_ONE;
      end else if (csr_write_enable) begin
         case (csr_index)
            afie_pkg::CSR_PCM_MODE: pcm_mode_ff <= csr_data[0];
            afie_pkg::CSR_ALIGN:    align_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Frame table. Written by an append at the entry count; read every
   // cycle at the address the sequencer presents, into the read data registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_offset_ff[entry_count_ff[afie_pkg::INDEX_WIDTH-1:0]] <= op_offset_ff;
         entry_length_ff[entry_count_ff[afie_pkg::INDEX_WIDTH-1:0]] <= op_length_ff;
         entry_start_ff[entry_count_ff[afie_pkg::INDEX_WIDTH-1:0]]  <= sample_total_ff;
      end
      rd_offset_ff <= entry_offset_ff[rd_addr];
      rd_length_ff <= entry_length_ff[rd_addr];
      rd_start_ff  <= entry_start_ff[rd_addr];
   end

   // ------------------------------------------------------------------
   // Sequencer state and working registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= afie_pkg::ST_IDLE;
         entry_count_ff  <= '0;
         cursor_frame_ff <= '0;
         cursor_byte_ff  <= '0;
         sample_total_ff <= '0;
         byte_total_ff   <= '0;
         largest_ff      <= '0;
         seg_count_ff    <= '0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         entry_count_ff  <= entry_count_in;
         cursor_frame_ff <= cursor_frame_in;
         cursor_byte_ff  <= cursor_byte_in;
         sample_total_ff <= sample_total_in;
         byte_total_ff   <= byte_total_in;
         largest_ff      <= largest_in;
         seg_count_ff    <= seg_count_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= emit;
      end
   end

   always_ff @(posedge clock) begin
      op_mode_ff     <= op_mode_in;
      op_offset_ff   <= op_offset_in;
      op_length_ff   <= op_length_in;
      op_samples_ff  <= op_samples_in;
      op_target_ff   <= op_target_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      mid_ff         <= mid_in;
      room_ff        <= room_in;
      rem_ff         <= rem_in;
      bit_ctr_ff     <= bit_ctr_in;
      pend_offset_ff <= pend_offset_in;
      pend_length_ff <= pend_length_in;
      pend_found_ff  <= pend_found_in;
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_offset_ff <= (emit_length != '0) ? emit_offset : '0;
         rsp_length_ff <= emit_length;
         rsp_found_ff  <= emit_found;
         rsp_total_ff  <= sample_total_in;
         rsp_max_ff    <= largest_in;
         rsp_last_ff   <= emit_last;
      end
   end

   // ------------------------------------------------------------------
   // Next state, shared arithmetic and response forming
   // ------------------------------------------------------------------
   always_comb begin
      state_in        = state_ff;
      op_mode_in      = op_mode_ff;
      op_offset_in    = op_offset_ff;
      op_length_in    = op_length_ff;
      op_samples_in   = op_samples_ff;
      op_target_in    = op_target_ff;
      entry_count_in  = entry_count_ff;
      cursor_frame_in = cursor_frame_ff;
      cursor_byte_in  = cursor_byte_ff;
      sample_total_in = sample_total_ff;
      byte_total_in   = byte_total_ff;
      largest_in      = largest_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      room_in         = room_ff;
      rem_in          = rem_ff;
      bit_ctr_in      = bit_ctr_ff;
      seg_count_in    = seg_count_ff;
      pend_valid_in   = pend_valid_ff;
      pend_offset_in  = pend_offset_ff;
      pend_length_in  = pend_length_ff;
      pend_found_in   = pend_found_ff;
      rd_addr         = cursor_frame_ff[afie_pkg::INDEX_WIDTH-1:0];
      wr_en           = 1'b0;
      emit            = 1'b0;
      emit_status     = afie_pkg::STATUS_OK;
      emit_offset     = '0;
      emit_length     = '0;
      emit_found      = '0;
      emit_last       = 1'b1;

      sample_sum = {1'b0, sample_total_ff}
                 + (afie_pkg::SAMPLE_WIDTH + 1)'(op_samples_ff);
      align_eff  = (align_ff == '0) ? afie_pkg::ALIGN_ONE : align_ff;
      rem_trial  = {rem_ff, room_ff[afie_pkg::ROOM_MSB - bit_ctr_ff]};
      rem_step   = (rem_trial >= {1'b0, align_eff}) ? rem_trial - {1'b0, align_eff}
                                                    : rem_trial;
      frame_rem  = (cursor_byte_ff < rd_length_ff) ? rd_length_ff - cursor_byte_ff : '0;
      seg_offset = rd_offset_ff + afie_pkg::OFFSET_WIDTH'(cursor_byte_ff);
      seek_mid   = lo_ff + ((hi_ff - lo_ff) >> 1);
      seek_pick  = (lo_ff == '0) ? '0 : lo_ff - 1'b1;

      case (state_ff)
         afie_pkg::ST_IDLE: begin
            // The read port looks at the cursor frame here, so whole-frame reads and the
            // no-operation word find its entry ready in the next cycle.
            if (accept) begin
               op_mode_in    = req_mode;
               op_offset_in  = req_frame_offset;
               op_length_in  = req_frame_length;
               op_samples_in = req_frame_samples;
               op_target_in  = req_seek_sample;
               room_in       = req_read_size;
               case (req_mode)
                  afie_pkg::MODE_APPEND: state_in = afie_pkg::ST_APPEND;
                  afie_pkg::MODE_SEEK: begin
                     lo_in    = '0;
                     hi_in    = entry_count_ff;
                     state_in = afie_pkg::ST_SEEK_ADDR;
                  end
                  afie_pkg::MODE_READ: begin
                     if (pcm_mode_ff) begin
                        rem_in        = '0;
                        bit_ctr_in    = '0;
                        seg_count_in  = '0;
                        pend_valid_in = 1'b0;
                        state_in      = afie_pkg::ST_ALIGN;
                     end else begin
                        state_in = afie_pkg::ST_WF_EMIT;
                     end
                  end
                  default: state_in = afie_pkg::ST_CUR_EMIT;
               endcase
            end
         end

         afie_pkg::ST_APPEND: begin
            emit     = 1'b1;
            state_in = afie_pkg::ST_IDLE;
            if (entry_count_ff >= afie_pkg::FRAME_DEPTH_COUNT) begin
               emit_status = afie_pkg::STATUS_FULL;
               emit_found  = sample_total_ff;
            end else begin
               wr_en           = 1'b1;
               entry_count_in  = entry_count_ff + 1'b1;
               sample_total_in = sample_sum[afie_pkg::SAMPLE_WIDTH]
                               ? afie_pkg::SAMPLE_MAX
                               : sample_sum[afie_pkg::SAMPLE_WIDTH-1:0];
               byte_total_in   = byte_total_ff
                               + afie_pkg::BYTE_TOTAL_WIDTH'(op_length_ff);
               largest_in      = (op_length_ff > largest_ff) ? op_length_ff : largest_ff;
               emit_found      = sample_total_ff;
            end
         end

         afie_pkg::ST_SEEK_ADDR: begin
            if (lo_ff < hi_ff) begin
               mid_in   = seek_mid;
               rd_addr  = seek_mid[afie_pkg::INDEX_WIDTH-1:0];
               state_in = afie_pkg::ST_SEEK_CMP;
            end else begin
               // Last frame at or below the target, clamped to the first frame.
               rd_addr         = seek_pick[afie_pkg::INDEX_WIDTH-1:0];
               cursor_frame_in = seek_pick;
               cursor_byte_in  = '0;
               state_in        = afie_pkg::ST_SEEK_EMIT;
            end
         end

         afie_pkg::ST_SEEK_CMP: begin
            if (rd_start_ff <= op_target_ff) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            state_in = afie_pkg::ST_SEEK_ADDR;
         end

         afie_pkg::ST_SEEK_EMIT: begin
            emit     = 1'b1;
            state_in = afie_pkg::ST_IDLE;
            if (entry_count_ff == '0) begin
               emit_status = afie_pkg::STATUS_END;
            end else begin
               emit_found = rd_start_ff;
            end
         end

         afie_pkg::ST_ALIGN: begin
            // One bit of restoring remainder per cycle, most significant first.
            rem_in = rem_step[afie_pkg::ALIGN_WIDTH-1:0];
            if (bit_ctr_ff == afie_pkg::ROOM_MSB) begin
               room_in  = room_ff - afie_pkg::LENGTH_WIDTH'(rem_step);
               state_in = afie_pkg::ST_PCM_ADDR;
            end else begin
               bit_ctr_in = bit_ctr_ff + 1'b1;
            end
         end

         afie_pkg::ST_PCM_ADDR: begin
            if (cursor_in_table && (room_ff != '0) && (seg_count_ff < afie_pkg::MAX_SEG_COUNT))
            begin
               state_in = afie_pkg::ST_PCM_SEG;
            end else if (pend_valid_ff) begin
               emit          = 1'b1;
               emit_offset   = pend_offset_ff;
               emit_length   = pend_length_ff;
               emit_found    = pend_found_ff;
               pend_valid_in = 1'b0;
               state_in      = afie_pkg::ST_IDLE;
            end else begin
               state_in = afie_pkg::ST_CUR_EMIT;
            end
         end

         afie_pkg::ST_PCM_SEG: begin
            if ((frame_rem > room_ff) || (frame_rem != '0)) begin
               // A new segment pushes out the one held back, which is then
               // known not to be the final word.
               if (pend_valid_ff) begin
                  emit        = 1'b1;
                  emit_offset = pend_offset_ff;
                  emit_length = pend_length_ff;
                  emit_found  = pend_found_ff;
                  emit_last   = 1'b0;
               end
               pend_valid_in  = 1'b1;
               pend_offset_in = seg_offset;
               pend_found_in  = rd_start_ff;
               seg_count_in   = seg_count_ff + 1'b1;
            end
            if (frame_rem > room_ff) begin
               pend_length_in = room_ff;
               cursor_byte_in = cursor_byte_ff + room_ff;
               room_in        = '0;
            end else begin
               // An empty frame leaves the segment held back untouched.
               if (frame_rem != '0) begin
                  pend_length_in = frame_rem;
               end
               room_in         = room_ff - frame_rem;
               cursor_byte_in  = '0;
               cursor_frame_in = cursor_frame_ff + 1'b1;
            end
            state_in = afie_pkg::ST_PCM_ADDR;
         end

         afie_pkg::ST_WF_EMIT: begin
            emit     = 1'b1;
            state_in = afie_pkg::ST_IDLE;
            if (!cursor_in_table) begin
               emit_status = afie_pkg::STATUS_END;
               emit_found  = sample_total_ff;
            end else if (rd_length_ff > room_ff) begin
               emit_status = afie_pkg::STATUS_TOO_BIG;
               emit_found  = rd_start_ff;
            end else begin
               emit_offset     = rd_offset_ff;
               emit_length     = rd_length_ff;
               emit_found      = rd_start_ff;
               cursor_frame_in = cursor_frame_ff + 1'b1;
               cursor_byte_in  = '0;
            end
         end

         afie_pkg::ST_CUR_EMIT: begin
            emit     = 1'b1;
            state_in = afie_pkg::ST_IDLE;
            if ((op_mode_ff == afie_pkg::MODE_READ) && !cursor_in_table) begin
               emit_status = afie_pkg::STATUS_END;
            end
            emit_found = cursor_in_table ? rd_start_ff : sample_total_ff;
         end

         default: state_in = afie_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_segment_offset   = rsp_offset_ff;
   assign rsp_segment_length   = rsp_length_ff;
   assign rsp_found_sample     = rsp_found_ff;
   assign rsp_total_samples    = rsp_total_ff;
   assign rsp_max_frame_length = rsp_max_ff;
   assign rsp_last             = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------

   // A taken request word always starts a multi-cycle operation.
   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request word taken but block not busy");

   // Response words come only out of an operation in progress.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response word without an operation in progress");

   // The final word of an operation is never followed at once by another.
   a_last_then_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("response word straight after a final word");

   // The cursor never runs past the filled part of the table.
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (cursor_frame_ff <= entry_count_ff) && (entry_count_ff <= afie_pkg::FRAME_DEPTH_COUNT))
      else $error("cursor or entry count out of range");

endmodule

`default_nettype wire
